### sv/jew_pkg.sv
`default_nettype none
package jew_pkg;

	typedef enum logic [3:0] {
		CMD_OPEN_OBJ  = 4'd0,
		CMD_OPEN_ARR  = 4'd1,
		CMD_CLOSE_OBJ = 4'd2,
		CMD_CLOSE_ARR = 4'd3,
		CMD_STR_BEGIN = 4'd4,
		CMD_KEY_BEGIN = 4'd5,
		CMD_CHAR      = 4'd6,
		CMD_STR_END   = 4'd7,
		CMD_KEY_END   = 4'd8,
		CMD_INT       = 4'd9,
		CMD_BOOL      = 4'd10,
		CMD_NULL      = 4'd11,
		CMD_OBJ_SEP   = 4'd12,
		CMD_ARR_SEP   = 4'd13,
		CMD_FLUSH     = 4'd14,
		CMD_NONE      = 4'd15
	} cmd_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [63:0] int_value;
		logic [7:0]         char_byte;
		logic               bool_value;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_req_t;

	// Job handed from front to back: everything already decided.
	// Emission order: nl, tabs, head bytes (up to 6), int digits, tail nl.
	typedef struct packed {
		logic        nl;
		logic [5:0]  tabs;
		logic [2:0]  head_n;
		logic [47:0] head;      // byte 0 in [7:0]
		logic        is_int;
		logic [63:0] mag;
		logic        tail_nl;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_NL, BK_TABS, BK_HEAD, BK_CONV, BK_SKIP, BK_DIG, BK_TAIL
	} bk_state_t;

	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_TAB = 8'd9;

	function automatic logic [7:0] hex_ch(input logic [3:0] v);
		hex_ch = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
	endfunction

endpackage
`default_nettype wire

### sv/json_event_writer_core.sv
`default_nettype none
// channel | handshake        | payload
// in      | push / full      | in_req_t  (cmd, int_value, char_byte, bool_value)
// out     | pop / empty      | out_req_t (out_byte, last_byte)
// cfg     | cfg_we           | cfg_data  (pretty_mode)
// Front classifies one request per cycle, while the queue is not full, into
// a two-entry job queue. Back takes a job while idle, then emits one byte
// per cycle while the output is not stalled; an integer is first converted
// by a shift-add-3 decimal conversion, then leading zeros are dropped.
// Reset clears depth, flags, queue and output valid flag. Output stalls
// back up through the queue to full.
module json_event_writer_core
	import jew_pkg::*;
#(
	parameter int MAX_DEPTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic    cfg_data,
	input  wire logic    push,
	output logic         full,
	input  wire in_req_t in_req,
	input  wire logic    pop,
	output logic         empty,
	output out_req_t     out_req
);

	logic pretty_q;
	job_t fjob, qjob;
	logic qempty, qtake, acc;

	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pretty_q <= 1'b0;
		else if (cfg_we)
			pretty_q <= cfg_data;
	end

	jew_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .pretty(pretty_q),
		.req(in_req), .req_valid(acc), .job(fjob)
	);

	// jobs with no bytes are dropped at the queue input
	logic wr;
	assign wr = acc && (fjob.nl || fjob.tabs != 6'd0 || fjob.head_n != 3'd0 ||
		fjob.is_int || fjob.tail_nl);

	jew_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wr_job(fjob), .full(full),
		.rd(qtake), .empty(qempty), .rd_job(qjob)
	);

	jew_back u_back (
		.clk(clk), .arst_n(arst_n), .job_empty(qempty), .job(qjob),
		.job_take(qtake), .res(out_req), .empty(empty), .pop(pop)
	);

endmodule
`default_nettype wire

### sv/jew_front.sv
`default_nettype none
module jew_front
	import jew_pkg::*;
#(
	parameter int MAX_DEPTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pretty,
	input  wire in_req_t req,
	input  wire logic    req_valid,
	output job_t         job
);

	logic [5:0] depth_q;
	logic       nlp_q, sup_q;
	logic [5:0] depth_d;
	logic       nlp_d, sup_d;

	// classify the request into a job, and update the format state
	always_comb begin
		logic [7:0] c;
		c = req.char_byte;
		job = '0;
		depth_d = depth_q;
		nlp_d = nlp_q;
		sup_d = sup_q;
		case (cmd_t'(req.cmd))
			CMD_OPEN_OBJ, CMD_OPEN_ARR: begin
				job.head_n = 3'd1;
				job.head[7:0] = (req.cmd == CMD_OPEN_OBJ) ? 8'h7B : 8'h5B;
				if (pretty) begin
					job.nl = nlp_q;
					job.tabs = sup_q ? 6'd0 : depth_q;
					if (depth_q < 6'(MAX_DEPTH))
						depth_d = depth_q + 6'd1;
					nlp_d = 1'b1;
					sup_d = 1'b0;
				end
			end
			CMD_CLOSE_OBJ, CMD_CLOSE_ARR: begin
				job.head_n = 3'd1;
				job.head[7:0] = (req.cmd == CMD_CLOSE_OBJ) ? 8'h7D : 8'h5D;
				if (pretty) begin
					job.nl = !nlp_q;
					if (depth_q != 6'd0)
						depth_d = depth_q - 6'd1;
					job.tabs = nlp_q ? 6'd0 : depth_d;
					nlp_d = 1'b0;
					sup_d = 1'b0;
				end
			end
			CMD_STR_BEGIN, CMD_INT, CMD_BOOL, CMD_NULL, CMD_KEY_BEGIN: begin
				if (pretty) begin
					job.nl = nlp_q;
					nlp_d = 1'b0;
					job.tabs = (sup_q && req.cmd != CMD_KEY_BEGIN) ? 6'd0 : depth_q;
				end
				case (cmd_t'(req.cmd))
					CMD_INT: begin
						job.is_int = 1'b1;
						job.mag = req.int_value[63] ? 64'(-req.int_value) : req.int_value;
						if (req.int_value[63]) begin
							job.head_n = 3'd1;
							job.head[7:0] = 8'h2D;
						end
					end
					CMD_BOOL: begin
						if (req.bool_value) begin
							job.head_n = 3'd4;
							job.head[31:0] = {8'h65, 8'h75, 8'h72, 8'h74};
						end else begin
							job.head_n = 3'd5;
							job.head[39:0] = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
						end
					end
					CMD_NULL: begin
						job.head_n = 3'd4;
						job.head[31:0] = {8'h6C, 8'h6C, 8'h75, 8'h6E};
					end
					default: begin
						job.head_n = 3'd1;
						job.head[7:0] = 8'h22;
					end
				endcase
			end
			CMD_CHAR: begin
				job.head_n = 3'd2;
				job.head[7:0] = 8'h5C;
				case (c)
					8'h22: job.head[15:8] = 8'h22;
					8'h5C: job.head[15:8] = 8'h5C;
					8'd8:  job.head[15:8] = 8'h62;
					8'd12: job.head[15:8] = 8'h66;
					8'd10: job.head[15:8] = 8'h6E;
					8'd13: job.head[15:8] = 8'h72;
					8'd9:  job.head[15:8] = 8'h74;
					default: begin
						if (c >= 8'd32) begin
							job.head_n = 3'd1;
							job.head[7:0] = c;
						end else begin
							job.head_n = 3'd6;
							job.head[47:8] = {hex_ch(c[3:0]), hex_ch(c[7:4]),
								8'h30, 8'h30, 8'h75};
						end
					end
				endcase
			end
			CMD_STR_END: begin
				job.head_n = 3'd1;
				job.head[7:0] = 8'h22;
			end
			CMD_KEY_END: begin
				job.head_n = 3'd2;
				job.head[15:0] = {8'h3A, 8'h22};
				sup_d = 1'b1;
			end
			CMD_OBJ_SEP, CMD_ARR_SEP: begin
				job.head_n = 3'd1;
				job.head[7:0] = 8'h2C;
				if (pretty) begin
					job.tail_nl = 1'b1;
					sup_d = 1'b0;
				end
			end
			CMD_FLUSH: job.tail_nl = pretty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			nlp_q <= 1'b0;
			sup_q <= 1'b0;
		end else if (req_valid) begin
			depth_q <= depth_d;
			nlp_q <= nlp_d;
			sup_q <= sup_d;
		end
	end

endmodule
`default_nettype wire

### sv/jew_queue.sv
`default_nettype none
module jew_queue
	import jew_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t wr_job,
	output logic      full,
	input  wire logic rd,
	output logic      empty,
	output job_t      rd_job
);

	// two-entry job queue
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule
`default_nettype wire

### sv/jew_back.sv
`default_nettype none
module jew_back
	import jew_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_empty,
	input  wire job_t job,
	output logic      job_take,
	output out_req_t  res,
	output logic      empty,
	input  wire logic pop
);

	bk_state_t   st_q, st_d;
	job_t        j_q;
	logic [5:0]  cnt_q;
	logic [63:0] bin_q;
	logic [79:0] bcd_q;    // most significant digit in [79:76]
	logic [79:0] bcd_adj;
	logic [4:0]  nd_q;
	logic        out_v_q;
	out_req_t    out_q;

	// state after the current phase ends
	function automatic bk_state_t after_nl(input job_t x);
		if (x.tabs != 6'd0) return BK_TABS;
		if (x.head_n != 3'd0) return BK_HEAD;
		if (x.is_int) return BK_CONV;
		if (x.tail_nl) return BK_TAIL;
		return BK_IDLE;
	endfunction

	function automatic bk_state_t after_head(input job_t x);
		if (x.is_int) return BK_CONV;
		if (x.tail_nl) return BK_TAIL;
		return BK_IDLE;
	endfunction

	logic       stall;
	logic       emit;
	logic [7:0] byt;
	logic       lst;
	bk_state_t  nxt;

	assign stall = out_v_q && !pop;
	assign empty = !out_v_q;
	assign res = out_q;
	assign job_take = (st_q == BK_IDLE) && !job_empty;

	// shift-add-3 correction on every BCD digit
	always_comb begin
		for (int i = 0; i < 20; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (!job_empty) st_d = job.nl ? BK_NL : after_nl(job);
			BK_NL:   if (!stall) st_d = after_nl(j_q);
			BK_TABS: if (!stall && cnt_q == j_q.tabs - 6'd1) begin
				st_d = (j_q.head_n != 3'd0) ? BK_HEAD : after_head(j_q);
			end
			BK_HEAD: if (!stall && cnt_q == 6'(j_q.head_n) - 6'd1) st_d = after_head(j_q);
			BK_CONV: if (cnt_q == 6'd63) st_d = BK_SKIP;
			BK_SKIP: if (bcd_q[79:76] != 4'd0 || nd_q == 5'd1) st_d = BK_DIG;
			BK_DIG:  if (!stall && nd_q == 5'd1) st_d = j_q.tail_nl ? BK_TAIL : BK_IDLE;
			BK_TAIL: if (!stall) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// byte produced this cycle
	always_comb begin
		emit = 1'b0;
		byt = 8'd0;
		nxt = st_d;
		case (st_q)
			BK_NL:   begin emit = !stall; byt = CH_NL; end
			BK_TABS: begin emit = !stall; byt = CH_TAB; end
			BK_HEAD: begin emit = !stall; byt = j_q.head[{cnt_q[2:0], 3'd0} +: 8]; end
			BK_DIG:  begin emit = !stall; byt = 8'h30 + {4'd0, bcd_q[79:76]}; end
			BK_TAIL: begin emit = !stall; byt = CH_NL; end
			default: ;
		endcase
		lst = nxt == BK_IDLE;
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && !job_empty) begin
			j_q <= job;
			bin_q <= job.mag;
			bcd_q <= '0;
			nd_q <= 5'd20;
		end
		// one magnitude bit per cycle into the BCD register
		if (st_q == BK_CONV) begin
			bcd_q <= {bcd_adj[78:0], bin_q[63]};
			bin_q <= {bin_q[62:0], 1'b0};
		end
		// drop leading zero digits, keeping at least one
		if (st_q == BK_SKIP && st_d == BK_SKIP) begin
			bcd_q <= {bcd_q[75:0], 4'd0};
			nd_q <= nd_q - 5'd1;
		end
		if (st_q == BK_DIG && !stall) begin
			bcd_q <= {bcd_q[75:0], 4'd0};
			nd_q <= nd_q - 5'd1;
		end
		if (emit)
			out_q <= '{out_byte: byt, last_byte: lst};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_d != st_q)
				cnt_q <= '0;
			else if (emit || st_q == BK_CONV)
				cnt_q <= cnt_q + 6'd1;
			if (emit)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
